// ===== rtl/core/dense_layer_train_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dense layer training engine
// Implication checks sampled on aclk, muted while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DENSE_LAYER_TRAIN_ENGINE_MACROS_SVH
`define DENSE_LAYER_TRAIN_ENGINE_MACROS_SVH

// same-cycle implication
`define DLTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DLTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dlte_pkg.sv =====
// ----------------------------------------------------------------------------
// dlte_pkg
// Shared sizes, codes, control structs and saturation for the layer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dlte_pkg;

    localparam int MAX_IN     = 64;
    localparam int MAX_OUT    = 64;
    localparam int DATA_WIDTH = 16;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int LR_W       = 16;
    localparam int MUL_W      = DATA_WIDTH + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 2 * DATA_WIDTH + IDX_W + 2;
    localparam int CFG_A_W    = 2;
    localparam int CFG_D_W    = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;

    localparam logic [CFG_A_W-1:0] CFG_IN_COUNT   = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_OUT_COUNT  = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_LEARN_RATE = 2'd2;

    typedef enum logic [2:0] {
        ACT_LOAD_W = 3'd0,
        ACT_LOAD_B = 3'd1,
        ACT_FWD    = 3'd2,
        ACT_BWD    = 3'd3,
        ACT_UPD    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_FWD = 2'd0,
        KIND_BWD = 2'd1,
        KIND_UPD = 2'd2
    } kind_t;

    typedef struct packed {
        logic              clear;
        logic [ADDR_W-1:0] clear_addr;
        logic              store;
        logic              issue;
        kind_t             op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              first;
        logic              emit;
        logic              last;
        logic              out_load;
        logic [LR_W-1:0]   learn_rate;
    } dlte_cmd_t;

    typedef struct packed {
        logic res_ready;
        logic out_free;
    } dlte_status_t;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (DATA_WIDTH - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    function automatic logic [DATA_WIDTH-1:0] sat_data(input logic signed [ACC_W-1:0] a);
        logic [DATA_WIDTH-1:0] r;
        if (a > SAT_MAX) begin
            r = SAT_MAX[DATA_WIDTH-1:0];
        end else if (a < SAT_MIN) begin
            r = SAT_MIN[DATA_WIDTH-1:0];
        end else begin
            r = a[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dlte_datapath.sv =====
// ----------------------------------------------------------------------------
// dlte_datapath
// Weight, bias, gradient and vector stores, MAC pipeline and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dlte_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire dlte_pkg::dlte_cmd_t             cmd,
    output dlte_pkg::dlte_status_t               status,
    input  wire logic [2:0]                      in_action,
    input  wire logic [dlte_pkg::IDX_W-1:0]      in_row,
    input  wire logic [dlte_pkg::IDX_W-1:0]      in_col,
    input  wire logic [dlte_pkg::DATA_WIDTH-1:0] in_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [1:0]                           m_kind,
    output logic [dlte_pkg::IDX_W-1:0]           m_index,
    output logic [dlte_pkg::DATA_WIDTH-1:0]      m_result,
    output logic                                 m_last
);
    import dlte_pkg::*;

    localparam int W_DEPTH = MAX_IN * MAX_OUT;

    logic [DATA_WIDTH-1:0] wmem  [W_DEPTH];
    logic [DATA_WIDTH-1:0] wgmem [W_DEPTH];
    logic [DATA_WIDTH-1:0] bmem  [MAX_OUT];
    logic [DATA_WIDTH-1:0] bgmem [MAX_OUT];
    logic [DATA_WIDTH-1:0] xmem  [MAX_IN];
    logic [DATA_WIDTH-1:0] gmem  [MAX_OUT];

    // stage 1: registered memory reads
    logic                  s1_valid_reg, s1_first_reg, s1_emit_reg, s1_last_reg;
    kind_t                 s1_op_reg;
    logic [IDX_W-1:0]      s1_r_reg, s1_c_reg;
    logic [DATA_WIDTH-1:0] s1_w_reg, s1_wg_reg, s1_b_reg, s1_bg_reg, s1_x_reg, s1_g_reg;
    logic [LR_W-1:0]       s1_lr_reg;

    // stage 2: products
    logic                     s2_valid_reg, s2_first_reg, s2_emit_reg, s2_last_reg;
    kind_t                    s2_op_reg;
    logic [IDX_W-1:0]         s2_r_reg, s2_c_reg;
    logic [DATA_WIDTH-1:0]    s2_w_reg, s2_b_reg, s2_g_reg;
    logic signed [PROD_W-1:0] s2_pm_reg, s2_pa_reg;

    logic signed [ACC_W-1:0] acc_reg, acc_init, acc_sum;

    logic                  res_ready_reg, res_ready_next;
    kind_t                 res_kind_reg;
    logic [IDX_W-1:0]      res_index_reg;
    logic [DATA_WIDTH-1:0] res_value_reg;
    logic                  res_last_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_kind_reg;
    logic [IDX_W-1:0]      m_index_reg;
    logic [DATA_WIDTH-1:0] m_result_reg;
    logic                  m_last_reg;

    logic signed [MUL_W-1:0] ma_main, mb_main, ma_aux, mb_aux;

    logic                  w_we, wg_we, b_we, bg_we;
    logic [ADDR_W-1:0]     w_addr, wg_addr;
    logic [IDX_W-1:0]      b_addr, bg_addr;
    logic [DATA_WIDTH-1:0] w_wd, wg_wd, b_wd, bg_wd;

    logic signed [ACC_W-1:0] step_w, step_b, diff_w, diff_b, gx_sh;
    logic                    s2_upd, s2_bwd;

    // read port
    always_ff @(posedge aclk) begin
        s1_w_reg  <= wmem[{cmd.row, cmd.col}];
        s1_wg_reg <= wgmem[{cmd.row, cmd.col}];
        s1_b_reg  <= bmem[cmd.row];
        s1_bg_reg <= bgmem[cmd.row];
        s1_x_reg  <= xmem[cmd.col];
        s1_g_reg  <= gmem[cmd.row];
        s1_op_reg    <= cmd.op;
        s1_r_reg     <= cmd.row;
        s1_c_reg     <= cmd.col;
        s1_first_reg <= cmd.first;
        s1_emit_reg  <= cmd.emit;
        s1_last_reg  <= cmd.last;
        s1_lr_reg    <= cmd.learn_rate;
    end

    always_comb begin
        ma_main = $signed({s1_w_reg[DATA_WIDTH-1], s1_w_reg});
        mb_main = $signed({s1_x_reg[DATA_WIDTH-1], s1_x_reg});
        ma_aux  = $signed({s1_g_reg[DATA_WIDTH-1], s1_g_reg});
        mb_aux  = $signed({s1_x_reg[DATA_WIDTH-1], s1_x_reg});
        case (s1_op_reg)
            KIND_FWD: begin
                mb_main = $signed({s1_x_reg[DATA_WIDTH-1], s1_x_reg});
            end
            KIND_BWD: begin
                mb_main = $signed({s1_g_reg[DATA_WIDTH-1], s1_g_reg});
            end
            KIND_UPD: begin
                ma_main = $signed({1'b0, s1_lr_reg});
                mb_main = $signed({s1_wg_reg[DATA_WIDTH-1], s1_wg_reg});
                ma_aux  = $signed({1'b0, s1_lr_reg});
                mb_aux  = $signed({s1_bg_reg[DATA_WIDTH-1], s1_bg_reg});
            end
            default: begin
                mb_main = $signed({s1_x_reg[DATA_WIDTH-1], s1_x_reg});
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        s2_pm_reg    <= ma_main * mb_main;
        s2_pa_reg    <= ma_aux * mb_aux;
        s2_w_reg     <= s1_w_reg;
        s2_b_reg     <= s1_b_reg;
        s2_g_reg     <= s1_g_reg;
        s2_op_reg    <= s1_op_reg;
        s2_r_reg     <= s1_r_reg;
        s2_c_reg     <= s1_c_reg;
        s2_first_reg <= s1_first_reg;
        s2_emit_reg  <= s1_emit_reg;
        s2_last_reg  <= s1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // accumulate: bias seeds the forward sum in Q24.16
    always_comb begin
        acc_init = '0;
        if (s2_op_reg == KIND_FWD) begin
            acc_init = ACC_W'($signed(s2_b_reg)) <<< 8;
        end
        acc_sum = (s2_first_reg ? acc_init : acc_reg) + ACC_W'(s2_pm_reg);
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            acc_reg <= acc_sum;
        end
    end

    assign s2_upd = s2_valid_reg && (s2_op_reg == KIND_UPD);
    assign s2_bwd = s2_valid_reg && (s2_op_reg == KIND_BWD);

    always_comb begin
        step_w = ACC_W'(s2_pm_reg) >>> 16;
        step_b = ACC_W'(s2_pa_reg) >>> 16;
        diff_w = ACC_W'($signed(s2_w_reg)) - step_w;
        diff_b = ACC_W'($signed(s2_b_reg)) - step_b;
        gx_sh  = ACC_W'(s2_pa_reg) >>> 8;
    end

    // store write ports
    always_comb begin
        w_we   = 1'b0;
        w_addr = {s2_r_reg, s2_c_reg};
        w_wd   = sat_data(diff_w);
        if (cmd.store && (in_action == ACT_LOAD_W)) begin
            w_we   = 1'b1;
            w_addr = {in_row, in_col};
            w_wd   = in_value;
        end else if (s2_upd) begin
            w_we = 1'b1;
        end

        b_we   = 1'b0;
        b_addr = s2_r_reg;
        b_wd   = sat_data(diff_b);
        if (cmd.clear && (cmd.clear_addr[ADDR_W-1:IDX_W] == '0)) begin
            b_we   = 1'b1;
            b_addr = cmd.clear_addr[IDX_W-1:0];
            b_wd   = '0;
        end else if (cmd.store && (in_action == ACT_LOAD_B)) begin
            b_we   = 1'b1;
            b_addr = in_row;
            b_wd   = in_value;
        end else if (s2_upd && (s2_c_reg == '0)) begin
            b_we = 1'b1;
        end

        wg_we   = 1'b0;
        wg_addr = {s2_r_reg, s2_c_reg};
        wg_wd   = sat_data(gx_sh);
        if (cmd.clear) begin
            wg_we   = 1'b1;
            wg_addr = cmd.clear_addr;
            wg_wd   = '0;
        end else if (s2_bwd) begin
            wg_we = 1'b1;
        end

        bg_we   = 1'b0;
        bg_addr = s2_r_reg;
        bg_wd   = s2_g_reg;
        if (cmd.clear && (cmd.clear_addr[ADDR_W-1:IDX_W] == '0)) begin
            bg_we   = 1'b1;
            bg_addr = cmd.clear_addr[IDX_W-1:0];
            bg_wd   = '0;
        end else if (s2_bwd && (s2_c_reg == '0)) begin
            bg_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (w_we) begin
            wmem[w_addr] <= w_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (wg_we) begin
            wgmem[wg_addr] <= wg_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            bmem[b_addr] <= b_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (bg_we) begin
            bgmem[bg_addr] <= bg_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store && (in_action == ACT_FWD)) begin
            xmem[in_col] <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store && (in_action == ACT_BWD)) begin
            gmem[in_row] <= in_value;
        end
    end

    // finished result, held until the output register frees up
    always_comb begin
        res_ready_next = res_ready_reg;
        if (cmd.out_load) begin
            res_ready_next = 1'b0;
        end
        if (s2_valid_reg && s2_emit_reg) begin
            res_ready_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_ready_reg <= 1'b0;
        end else begin
            res_ready_reg <= res_ready_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s2_emit_reg) begin
            res_kind_reg  <= s2_op_reg;
            res_index_reg <= (s2_op_reg == KIND_BWD) ? s2_c_reg :
                             (s2_op_reg == KIND_FWD) ? s2_r_reg : '0;
            res_value_reg <= (s2_op_reg == KIND_UPD) ? '0 : sat_data(acc_sum >>> 8);
            res_last_reg  <= s2_last_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_kind_reg   <= res_kind_reg;
            m_index_reg  <= res_index_reg;
            m_result_reg <= res_value_reg;
            m_last_reg   <= res_last_reg;
        end
    end

    assign status.res_ready = res_ready_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_kind   = m_kind_reg;
    assign m_index  = m_index_reg;
    assign m_result = m_result_reg;
    assign m_last   = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dlte_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlte_ctrl
// Configuration registers, clearing sweep and the loop sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dense_layer_train_engine_macros.svh"

module dlte_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [dlte_pkg::CFG_A_W-1:0]  cfg_addr,
    input  wire logic [dlte_pkg::CFG_D_W-1:0]  cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [2:0]                    in_action,
    input  wire logic [dlte_pkg::IDX_W-1:0]    in_row,
    input  wire logic [dlte_pkg::IDX_W-1:0]    in_col,
    output dlte_pkg::dlte_cmd_t                cmd,
    input  wire dlte_pkg::dlte_status_t        status
);
    import dlte_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_WAIT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    kind_t             op_reg, op_next;
    logic [IDX_W-1:0]  outer_reg, outer_next, inner_reg, inner_next;
    logic [CNT_W-1:0]  in_count_reg, out_count_reg;
    logic [LR_W-1:0]   lr_reg;

    logic [CNT_W-1:0] n_in, n_out, n_outer, n_inner;
    logic             inner_end, outer_end, s_fire, trigger;

    function automatic logic [CNT_W-1:0] clamp(input logic [CNT_W-1:0] c,
                                               input logic [CNT_W-1:0] mx);
        logic [CNT_W-1:0] r;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (c > mx) begin
            r = mx;
        end else begin
            r = c;
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_count_reg  <= CNT_W'(MAX_IN);
            out_count_reg <= CNT_W'(MAX_OUT);
            lr_reg        <= LR_W'(655);
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_IN_COUNT:   in_count_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_OUT_COUNT:  out_count_reg <= cfg_wdata[CNT_W-1:0];
                CFG_LEARN_RATE: lr_reg        <= cfg_wdata[LR_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_in    = clamp(in_count_reg, CNT_W'(MAX_IN));
    assign n_out   = clamp(out_count_reg, CNT_W'(MAX_OUT));
    assign n_outer = (op_reg == KIND_BWD) ? n_in : n_out;
    assign n_inner = (op_reg == KIND_BWD) ? n_out : n_in;

    assign inner_end = ({1'b0, inner_reg} == (n_inner - CNT_W'(1)));
    assign outer_end = ({1'b0, outer_reg} == (n_outer - CNT_W'(1)));

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        case (action_t'(in_action))
            ACT_FWD: trigger = ({1'b0, in_col} == (n_in - CNT_W'(1)));
            ACT_BWD: trigger = ({1'b0, in_row} == (n_out - CNT_W'(1)));
            ACT_UPD: trigger = 1'b1;
            default: trigger = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        outer_next = outer_reg;
        inner_next = inner_reg;

        cmd            = '0;
        cmd.op         = op_reg;
        cmd.row        = (op_reg == KIND_BWD) ? inner_reg : outer_reg;
        cmd.col        = (op_reg == KIND_BWD) ? outer_reg : inner_reg;
        cmd.first      = (inner_reg == '0);
        cmd.last       = outer_end;
        cmd.emit       = inner_end && ((op_reg != KIND_UPD) || outer_end);
        cmd.learn_rate = lr_reg;
        cmd.clear_addr = clr_reg;

        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.store = s_fire;
                if (s_fire && trigger) begin
                    case (action_t'(in_action))
                        ACT_FWD: op_next = KIND_FWD;
                        ACT_BWD: op_next = KIND_BWD;
                        default: op_next = KIND_UPD;
                    endcase
                    outer_next = '0;
                    inner_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (inner_end) begin
                    inner_next = '0;
                    if (cmd.emit) begin
                        state_next = ST_WAIT;
                    end else begin
                        outer_next = outer_reg + IDX_W'(1);
                    end
                end else begin
                    inner_next = inner_reg + IDX_W'(1);
                end
            end
            ST_WAIT: begin
                // hold until the result is in and the output slot is free
                if (status.res_ready && status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (outer_end) begin
                        state_next = ST_IDLE;
                    end else begin
                        outer_next = outer_reg + IDX_W'(1);
                        state_next = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            op_reg    <= KIND_FWD;
            outer_reg <= '0;
            inner_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            op_reg    <= op_next;
            outer_reg <= outer_next;
            inner_reg <= inner_next;
        end
    end

    `DLTE_ASSERT_IMP(a_load_has_result, cmd.out_load, status.res_ready, "output load without result")
    `DLTE_ASSERT_IMP(a_inner_bound, state_reg == ST_RUN, {1'b0, inner_reg} < n_inner, "inner index out of range")
    `DLTE_ASSERT_NEXT(a_emit_waits, (state_reg == ST_RUN) && cmd.emit, state_reg == ST_WAIT, "emit not followed by wait")

endmodule

`default_nettype wire

// ===== rtl/core/dense_layer_train_engine.sv =====
// ----------------------------------------------------------------------------
// dense_layer_train_engine
// Fully connected layer, forward and backward pass with SGD update, Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel: s_tuser holds the action, s_tdata the
//   row, column and value. Loads and non-final vector elements are only stored.
//   The last forward element starts out_count rows of in_count MACs each; the
//   last backward element starts in_count columns of out_count MACs each and
//   writes the weight and bias gradients on the way. An update sweeps
//   out_count x in_count weights. One MAC unit runs one product per cycle while
//   the sequencer runs, and it pauses after each result until the output register
//   is free to take it.
//   Results leave on the m_ channel through one output register; while it is
//   stalled the sequencer holds and s_tready stays low until the run ends.
//   Reset (synchronous, aresetn low) restores the register defaults and then
//   sweeps the gradient and bias stores to zero; no request is taken during
//   the sweep. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_layer_train_engine (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [dlte_pkg::CFG_A_W-1:0]   cfg_addr,
    input  wire logic [dlte_pkg::CFG_D_W-1:0]   cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [dlte_pkg::S_TDATA_W-1:0] s_tdata,   // row, col, value, zero pad
    input  wire logic [2:0]                     s_tuser,   // action
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [dlte_pkg::M_TDATA_W-1:0]      m_tdata,   // index, result, zero pad
    output logic [1:0]                          m_tuser,   // kind
    output logic                                m_tlast
);
    import dlte_pkg::*;

    dlte_cmd_t    cmd;
    dlte_status_t status;

    logic [IDX_W-1:0]      in_row, in_col, m_index;
    logic [DATA_WIDTH-1:0] in_value, m_result;

    assign in_row   = s_tdata[IDX_W-1:0];
    assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
    assign in_value = s_tdata[2*IDX_W+DATA_WIDTH-1:2*IDX_W];

    dlte_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .in_action (s_tuser),
        .in_row    (in_row),
        .in_col    (in_col),
        .cmd       (cmd),
        .status    (status)
    );

    dlte_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_action (s_tuser),
        .in_row    (in_row),
        .in_col    (in_col),
        .in_value  (in_value),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_kind    (m_tuser),
        .m_index   (m_index),
        .m_result  (m_result),
        .m_last    (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - IDX_W - DATA_WIDTH){1'b0}}, m_result, m_index};

endmodule

`default_nettype wire
